// ===== sv/dllc_pkg.sv =====
package dllc_pkg;

    localparam int POOL_DEPTH_DEF = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int OP_WIDTH = 5;
    localparam int WORD_WIDTH = 32;

    localparam logic [OP_WIDTH-1:0] OP_CLEAR      = 5'd0;
    localparam logic [OP_WIDTH-1:0] OP_INS_FIRST  = 5'd1;
    localparam logic [OP_WIDTH-1:0] OP_INS_LAST   = 5'd2;
    localparam logic [OP_WIDTH-1:0] OP_CUR_FIRST  = 5'd3;
    localparam logic [OP_WIDTH-1:0] OP_CUR_LAST   = 5'd4;
    localparam logic [OP_WIDTH-1:0] OP_RD_FIRST   = 5'd5;
    localparam logic [OP_WIDTH-1:0] OP_RD_LAST    = 5'd6;
    localparam logic [OP_WIDTH-1:0] OP_DEL_FIRST  = 5'd7;
    localparam logic [OP_WIDTH-1:0] OP_DEL_LAST   = 5'd8;
    localparam logic [OP_WIDTH-1:0] OP_DEL_AFTER  = 5'd9;
    localparam logic [OP_WIDTH-1:0] OP_DEL_BEFORE = 5'd10;
    localparam logic [OP_WIDTH-1:0] OP_INS_AFTER  = 5'd11;
    localparam logic [OP_WIDTH-1:0] OP_INS_BEFORE = 5'd12;
    localparam logic [OP_WIDTH-1:0] OP_RD_CUR     = 5'd13;
    localparam logic [OP_WIDTH-1:0] OP_WRITE_CUR  = 5'd14;
    localparam logic [OP_WIDTH-1:0] OP_NEXT       = 5'd15;
    localparam logic [OP_WIDTH-1:0] OP_PREV       = 5'd16;
    localparam logic [OP_WIDTH-1:0] OP_QUERY      = 5'd17;

    typedef struct packed {
        logic [OP_WIDTH-1:0]   operation;
        logic [WORD_WIDTH-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [WORD_WIDTH-1:0] read_value;
        logic                  error;
        logic                  cursor_active;
    } out_word_t;

endpackage

// ===== sv/dllc_if.sv =====
interface dllc_if #(
    parameter int WIDTH = 1
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/dllc_ram.sv =====
module dllc_ram #(
    parameter int DEPTH = dllc_pkg::POOL_DEPTH_DEF,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== sv/doubly_linked_list_cursor_engine_unit.sv =====
// doubly linked list with a cursor over a pool of POOL_DEPTH nodes. each input
// word is one list operation; each produces exactly one output word with the
// read value, an error flag and the cursor state. node data, forward links and
// backward links sit in three single-port memories with registered reads; a
// sequencer walks each operation through read and write steps on those ports:
// ops that read no memory go from decode to result; reads wait on the value;
// deletes read the victim's links, then patch both neighbors; inserts take a
// free-list or fresh node, write it, then patch its neighbors; ops next to the
// cursor first read its links. accesses to the single link memory ports are
// serial. the next word is accepted once the sequencer is idle; a result still
// waiting in the output register holds the next op's last step until it leaves.
module doubly_linked_list_cursor_engine_unit #(
    parameter int POOL_DEPTH = dllc_pkg::POOL_DEPTH_DEF,
    parameter int DATA_WIDTH = dllc_pkg::DATA_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    dllc_if.sink   in_ch,
    dllc_if.source out_ch
);
    localparam int AW = $clog2(POOL_DEPTH);
    localparam int PW = $clog2(POOL_DEPTH + 1);
    localparam logic [PW-1:0] NIL = PW'(POOL_DEPTH);
    localparam int WW = dllc_pkg::WORD_WIDTH;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;  // decide on registered op
    localparam logic [3:0] S_RDC   = 4'd2;  // wait link read of cursor
    localparam logic [3:0] S_TGT   = 4'd3;  // unused; goes straight to output
    localparam logic [3:0] S_DRD   = 4'd4;  // wait link reads of delete victim
    localparam logic [3:0] S_DW1   = 4'd5;  // patch both neighbors
    localparam logic [3:0] S_DW2   = 4'd6;  // unused; goes straight to output
    localparam logic [3:0] S_FRD   = 4'd7;  // wait free list read
    localparam logic [3:0] S_IW1   = 4'd8;  // write new node
    localparam logic [3:0] S_IW2   = 4'd9;  // patch neighbors
    localparam logic [3:0] S_VRD   = 4'd10; // wait value read
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]   state_reg, state_next;
    logic [PW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [PW-1:0] cur_reg, cur_next, free_reg, free_next;
    logic [PW-1:0] fresh_reg, fresh_next;
    logic [dllc_pkg::OP_WIDTH-1:0] op_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    // working pointers: node being touched, left and right neighbors
    logic [PW-1:0] n_reg, n_next, a_reg, a_next, b_reg, b_next;
    logic          err_reg, err_next;
    logic [DATA_WIDTH-1:0] rd_reg, rd_next;
    logic          ovalid_reg, ovalid_next;
    dllc_pkg::out_word_t obuf_reg, obuf_next;

    // memory ports
    logic          v_we, nx_we, pv_we;
    logic [AW-1:0] v_addr, nx_addr, pv_addr;
    logic [DATA_WIDTH-1:0] v_wd, v_rd;
    logic [PW-1:0] nx_wd, nx_rd, pv_wd, pv_rd;

    dllc_ram #(.DEPTH(POOL_DEPTH), .WIDTH(DATA_WIDTH)) u_val (
        .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wd), .rdata(v_rd));
    dllc_ram #(.DEPTH(POOL_DEPTH), .WIDTH(PW)) u_next (
        .clk(clk), .we(nx_we), .addr(nx_addr), .wdata(nx_wd), .rdata(nx_rd));
    dllc_ram #(.DEPTH(POOL_DEPTH), .WIDTH(PW)) u_prev (
        .clk(clk), .we(pv_we), .addr(pv_addr), .wdata(pv_wd), .rdata(pv_rd));

    dllc_pkg::in_word_t in_w;
    assign in_w = dllc_pkg::in_word_t'(in_ch.payload);

    assign in_ch.ready    = (state_reg == S_IDLE);
    assign out_ch.valid   = ovalid_reg;
    assign out_ch.payload = obuf_reg;

    function automatic logic [AW-1:0] ad(input logic [PW-1:0] p);
        return p[AW-1:0];
    endfunction

    always_comb
    begin
        logic is_ins;
        logic [WW-1:0] rd_ext;
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cur_next    = cur_reg;
        free_next   = free_reg;
        fresh_next  = fresh_reg;
        n_next      = n_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        err_next    = err_reg;
        rd_next     = rd_reg;
        ovalid_next = ovalid_reg;
        obuf_next   = obuf_reg;
        v_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
        v_addr = ad(n_reg); nx_addr = ad(n_reg); pv_addr = ad(n_reg);
        v_wd = val_reg; nx_wd = b_reg; pv_wd = a_reg;
        is_ins = 1'b0;
        rd_ext = WW'($signed(rd_reg));

        if (out_ch.valid && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    err_next   = 1'b0;
                    rd_next    = '0;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = S_OUT;
                priority case (op_reg)
                    dllc_pkg::OP_CLEAR:
                    begin
                        head_next = NIL; tail_next = NIL; cur_next = NIL;
                        free_next = NIL; fresh_next = '0;
                    end
                    dllc_pkg::OP_INS_FIRST:
                    begin
                        a_next = NIL; b_next = head_reg; is_ins = 1'b1;
                    end
                    dllc_pkg::OP_INS_LAST:
                    begin
                        a_next = tail_reg; b_next = NIL; is_ins = 1'b1;
                    end
                    dllc_pkg::OP_CUR_FIRST: cur_next = head_reg;
                    dllc_pkg::OP_CUR_LAST:  cur_next = tail_reg;
                    dllc_pkg::OP_RD_FIRST, dllc_pkg::OP_RD_LAST, dllc_pkg::OP_RD_CUR:
                    begin
                        n_next = (op_reg == dllc_pkg::OP_RD_FIRST) ? head_reg :
                                 (op_reg == dllc_pkg::OP_RD_LAST) ? tail_reg : cur_reg;
                        if (n_next == NIL)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            v_addr = ad(n_next);
                            state_next = S_VRD;
                        end
                    end
                    dllc_pkg::OP_DEL_FIRST, dllc_pkg::OP_DEL_LAST:
                    begin
                        n_next = (op_reg == dllc_pkg::OP_DEL_FIRST) ? head_reg : tail_reg;
                        if (n_next != NIL)
                        begin
                            nx_addr = ad(n_next); pv_addr = ad(n_next);
                            state_next = S_DRD;
                        end
                    end
                    dllc_pkg::OP_WRITE_CUR:
                    begin
                        if (cur_reg != NIL)
                        begin
                            v_we = 1'b1; v_addr = ad(cur_reg);
                        end
                    end
                    dllc_pkg::OP_DEL_AFTER, dllc_pkg::OP_DEL_BEFORE,
                    dllc_pkg::OP_INS_AFTER, dllc_pkg::OP_INS_BEFORE,
                    dllc_pkg::OP_NEXT, dllc_pkg::OP_PREV:
                    begin
                        if (cur_reg != NIL)
                        begin
                            nx_addr = ad(cur_reg); pv_addr = ad(cur_reg);
                            state_next = S_RDC;
                        end
                    end
                    default: ;
                endcase
                if (is_ins)
                begin
                    if (free_reg != NIL)
                    begin
                        n_next = free_reg; nx_addr = ad(free_reg);
                        state_next = S_FRD;
                    end
                    else if (fresh_reg < NIL)
                    begin
                        n_next = fresh_reg; fresh_next = fresh_reg + 1'b1;
                        state_next = S_IW1;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
            end
            S_RDC:
            begin
                state_next = S_OUT;
                priority case (op_reg)
                    dllc_pkg::OP_NEXT: cur_next = nx_rd;
                    dllc_pkg::OP_PREV: cur_next = pv_rd;
                    dllc_pkg::OP_INS_AFTER:
                    begin
                        a_next = cur_reg; b_next = nx_rd; is_ins = 1'b1;
                    end
                    dllc_pkg::OP_INS_BEFORE:
                    begin
                        a_next = pv_rd; b_next = cur_reg; is_ins = 1'b1;
                    end
                    default:
                    begin
                        n_next = (op_reg == dllc_pkg::OP_DEL_AFTER) ? nx_rd : pv_rd;
                        if (n_next != NIL)
                        begin
                            nx_addr = ad(n_next); pv_addr = ad(n_next);
                            state_next = S_DRD;
                        end
                    end
                endcase
                if (is_ins)
                begin
                    if (free_reg != NIL)
                    begin
                        n_next = free_reg; nx_addr = ad(free_reg);
                        state_next = S_FRD;
                    end
                    else if (fresh_reg < NIL)
                    begin
                        n_next = fresh_reg; fresh_next = fresh_reg + 1'b1;
                        state_next = S_IW1;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
            end
            S_TGT: state_next = S_OUT;
            S_DRD:
            begin
                a_next = pv_rd; b_next = nx_rd;
                if (cur_reg == n_reg)
                begin
                    cur_next = NIL;
                end
                // return victim to the free list
                nx_we = 1'b1; nx_addr = ad(n_reg); nx_wd = free_reg;
                free_next = n_reg;
                state_next = S_DW1;
            end
            S_DW1:
            begin
                if (a_reg == NIL)
                begin
                    head_next = b_reg;
                end
                else
                begin
                    nx_we = 1'b1; nx_addr = ad(a_reg); nx_wd = b_reg;
                end
                if (b_reg == NIL)
                begin
                    tail_next = a_reg;
                end
                else
                begin
                    pv_we = 1'b1; pv_addr = ad(b_reg); pv_wd = a_reg;
                end
                state_next = S_OUT;
            end
            S_DW2: state_next = S_OUT;
            S_FRD:
            begin
                free_next = nx_rd;
                state_next = S_IW1;
            end
            S_IW1:
            begin
                v_we = 1'b1; nx_we = 1'b1; pv_we = 1'b1;
                state_next = S_IW2;
            end
            S_IW2:
            begin
                if (a_reg == NIL)
                begin
                    head_next = n_reg;
                end
                else
                begin
                    nx_we = 1'b1; nx_addr = ad(a_reg); nx_wd = n_reg;
                end
                if (b_reg == NIL)
                begin
                    tail_next = n_reg;
                end
                else
                begin
                    pv_we = 1'b1; pv_addr = ad(b_reg); pv_wd = n_reg;
                end
                state_next = S_OUT;
            end
            S_VRD:
            begin
                rd_next = v_rd;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    obuf_next.read_value    = rd_ext;
                    obuf_next.error         = err_reg;
                    obuf_next.cursor_active = (cur_reg != NIL);
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= NIL;
            tail_reg   <= NIL;
            cur_reg    <= NIL;
            free_reg   <= NIL;
            fresh_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cur_reg    <= cur_next;
            free_reg   <= free_next;
            fresh_reg  <= fresh_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            op_reg  <= in_w.operation;
            val_reg <= DATA_WIDTH'(in_w.value);
        end
        n_reg    <= n_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        err_reg  <= err_next;
        rd_reg   <= rd_next;
        obuf_reg <= obuf_next;
    end
endmodule
